// File: hw/rtl/tct_pkg.sv
// shared types and constants of the capacitive touch channel tracker
// no dependencies
`default_nettype none

package tct_pkg;

    localparam int CHANNELS   = 16;
    localparam int CH_W       = 4;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W      = 16;
    localparam int FRAC_W     = 8;
    localparam int PCOUNT_W   = 8;
    localparam int KEYS_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] FOLLOW_LIMIT = 16'd100;
    localparam logic [CNT_W-1:0] FOLLOW_BIG   = 16'd50;
    localparam logic [CNT_W-1:0] FOLLOW_SMALL = 16'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_FRACTION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_FRACTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GAP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DELAY      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_ON       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_ON        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_CHANNEL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED_MASK     = 3'd7;

    typedef struct packed {
        logic [FRAC_W-1:0] press_fraction;
        logic [FRAC_W-1:0] release_fraction;
        logic [CNT_W-1:0]  repeat_gap;
        logic [CNT_W-1:0]  clear_delay;
        logic              lowpass_on;
        logic              follow_on;
        logic [CH_W-1:0]   last_channel;
        logic [KEYS_W-1:0] enabled_mask;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]    filt;
        logic [CNT_W-1:0]    base;
        logic                key;
        logic                pressing;
        logic [PCOUNT_W-1:0] count;
        logic [CNT_W-1:0]    dur;
        logic [CNT_W-1:0]    rel;
    } t_chan;

endpackage

`default_nettype wire

// File: hw/rtl/tct_chan_eval.sv
// next state of one channel for a scan sample: filter, judge, follow, counters
// depends on tct_pkg
`default_nettype none

module tct_chan_eval (
    input  var tct_pkg::t_cfg             i_cfg,
    input  var tct_pkg::t_chan            i_cur,
    input  wire [tct_pkg::CNT_W-1:0]      i_raw,
    output tct_pkg::t_chan                o_next
);
    import tct_pkg::*;

    logic [CNT_W+1:0]          old3;
    logic [CNT_W-1:0]          lp;
    logic [CNT_W-1:0]          filt;
    logic [CNT_W-1:0]          base;
    logic                      above;
    logic [CNT_W-1:0]          diff;
    logic [CNT_W-1:0]          step;
    logic [CNT_W:0]            up_sum;
    logic [CNT_W-1:0]          base_up;
    logic [CNT_W-1:0]          drop;
    logic [CNT_W+FRAC_W-1:0]   drop_sh;
    logic [CNT_W+FRAC_W-1:0]   press_th;
    logic [CNT_W+FRAC_W-1:0]   rel_th;
    logic                      is_press;
    logic                      is_rel;

    always_comb begin
        old3     = {1'b0, i_cur.filt, 1'b0} + {2'b00, i_cur.filt};
        lp       = old3[CNT_W+1:2] + {4'b0000, i_raw[CNT_W-1:4]};
        filt     = i_cfg.lowpass_on ? lp : i_raw;
        base     = i_cur.base;
        above    = filt > base;
        diff     = filt - base;
        step     = (diff > FOLLOW_LIMIT) ? FOLLOW_BIG : FOLLOW_SMALL;
        up_sum   = {1'b0, base} + {1'b0, step};
        base_up  = up_sum[CNT_W] ? {CNT_W{1'b1}} : up_sum[CNT_W-1:0];
        drop     = base - filt;
        drop_sh  = {drop, {FRAC_W{1'b0}}};
        press_th = (CNT_W+FRAC_W)'(i_cfg.press_fraction) * (CNT_W+FRAC_W)'(base);
        rel_th   = (CNT_W+FRAC_W)'(i_cfg.release_fraction) * (CNT_W+FRAC_W)'(base);
        is_press = !above && (drop_sh >= press_th);
        is_rel   = above || (drop_sh <= rel_th);

        o_next      = i_cur;
        o_next.filt = filt;
        if (i_cfg.follow_on && above) begin
            o_next.key  = 1'b0;
            o_next.base = base_up;
        end else if (is_press) begin
            if (i_cfg.follow_on && (base != '0)) begin
                o_next.base = base - 1'b1;
            end
            o_next.key = 1'b1;
            if (i_cur.pressing) begin
                if (i_cur.dur != {CNT_W{1'b1}}) begin
                    o_next.dur = i_cur.dur + 1'b1;
                end
            end else if (i_cur.rel < i_cfg.repeat_gap) begin
                if (i_cur.count != {PCOUNT_W{1'b1}}) begin
                    o_next.count = i_cur.count + 1'b1;
                end
            end else begin
                o_next.count = PCOUNT_W'(1);
            end
            o_next.pressing = 1'b1;
            o_next.rel      = '0;
        end else if (is_rel) begin
            o_next.key = 1'b0;
            if (i_cur.rel >= i_cfg.repeat_gap) begin
                o_next.count = '0;
            end
            if (i_cur.rel >= i_cfg.clear_delay) begin
                o_next.dur = '0;
            end
            if (i_cur.rel != {CNT_W{1'b1}}) begin
                o_next.rel = i_cur.rel + 1'b1;
            end
            o_next.pressing = 1'b0;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tct_chan_state.sv
// per-channel state registers with scan write-back and baseline capture
// depends on tct_pkg
`default_nettype none

module tct_chan_state (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_wr,
    input  wire [tct_pkg::CH_IDX_W-1:0]   i_idx,
    input  var tct_pkg::t_chan            i_wdata,
    input  wire                           i_capture,
    input  wire [tct_pkg::KEYS_W-1:0]     i_mask,
    output tct_pkg::t_chan                o_rdata,
    output logic [tct_pkg::KEYS_W-1:0]    o_status
);
    import tct_pkg::*;

    logic [CNT_W-1:0]    r_filt     [CHANNELS];
    logic [CNT_W-1:0]    r_base     [CHANNELS];
    logic [CHANNELS-1:0] r_status;
    logic [CHANNELS-1:0] r_pressing;
    logic [PCOUNT_W-1:0] r_count    [CHANNELS];
    logic [CNT_W-1:0]    r_dur      [CHANNELS];
    logic [CNT_W-1:0]    r_rel      [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status   <= '0;
            r_pressing <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_filt[i]  <= '0;
                r_base[i]  <= '0;
                r_count[i] <= '0;
                r_dur[i]   <= '0;
                r_rel[i]   <= '0;
            end
        end else if (i_capture) begin
            for (int i = 0; i < CHANNELS; i++) begin
                if (i_mask[i]) begin
                    r_base[i] <= r_filt[i];
                end
            end
        end else if (i_wr) begin
            r_filt[i_idx]     <= i_wdata.filt;
            r_base[i_idx]     <= i_wdata.base;
            r_status[i_idx]   <= i_wdata.key;
            r_pressing[i_idx] <= i_wdata.pressing;
            r_count[i_idx]    <= i_wdata.count;
            r_dur[i_idx]      <= i_wdata.dur;
            r_rel[i_idx]      <= i_wdata.rel;
        end
    end

    always_comb begin
        o_rdata.filt     = r_filt[i_idx];
        o_rdata.base     = r_base[i_idx];
        o_rdata.key      = r_status[i_idx];
        o_rdata.pressing = r_pressing[i_idx];
        o_rdata.count    = r_count[i_idx];
        o_rdata.dur      = r_dur[i_idx];
        o_rdata.rel      = r_rel[i_idx];
        o_status         = KEYS_W'(r_status);
    end

endmodule

`default_nettype wire

// File: hw/rtl/capacitive_touch_channel_tracker.sv
// Capacitive touch channel tracker: one result per request, one request per cycle
// while the output is not stalled. A request passes an input register, then the
// channel state is read and updated and the result is registered in the output
// register; the state is written back as the result is registered, so a following
// request on the same channel sees the updated state. A stalled output's held result
// lets one further request into the input register. The user must write configuration
// through the plain write port only while idle; the block does not enforce this.
// depends on tct_pkg, tct_chan_eval, tct_chan_state
`default_nettype none

module capacitive_touch_channel_tracker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // write port
    input  wire                              i_cfg_we,
    input  wire [tct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [tct_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // request stream
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    input  wire [23:0]                       i_s_tdata,  // channel, raw_count, zero pad
    input  wire                              i_s_tuser,  // func
    // result stream
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // out_channel, filtered_value, baseline_value, key_pressed, press_count,
    // press_duration, release_duration, pressed_keys, zero pad
    output logic [95:0]                      o_m_tdata,
    output logic                             o_m_tlast   // sweep_done
);
    import tct_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic              r_in_func;
    logic [CH_W-1:0]   r_in_ch;
    logic [CNT_W-1:0]  r_in_raw;
    logic              r_out_valid;
    logic [95:0]       r_out_data;
    logic              r_out_last;

    logic              out_ready;
    logic              adv;
    logic              ch_ok;
    logic [CH_IDX_W-1:0] idx;
    t_chan             cur;
    t_chan             ev;
    t_chan             post;
    logic [KEYS_W-1:0] status;
    logic [KEYS_W-1:0] status_post;
    logic [KEYS_W-1:0] keys;
    logic [95:0]       n_out_data;
    logic              n_out_last;

    assign out_ready  = !r_out_valid || i_m_tready;
    assign adv        = r_in_valid && out_ready;
    assign o_s_tready = !r_in_valid || out_ready;
    assign ch_ok      = {1'b0, r_in_ch} < (CH_W+1)'(CHANNELS);
    assign idx        = r_in_ch[CH_IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_fraction   <= 8'd26;
            r_cfg.release_fraction <= 8'd13;
            r_cfg.repeat_gap       <= 16'd20;
            r_cfg.clear_delay      <= 16'd50;
            r_cfg.lowpass_on       <= 1'b1;
            r_cfg.follow_on        <= 1'b1;
            r_cfg.last_channel     <= 4'd15;
            r_cfg.enabled_mask     <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PRESS_FRACTION:   r_cfg.press_fraction   <= i_cfg_wdata[FRAC_W-1:0];
                CFG_RELEASE_FRACTION: r_cfg.release_fraction <= i_cfg_wdata[FRAC_W-1:0];
                CFG_REPEAT_GAP:       r_cfg.repeat_gap       <= i_cfg_wdata;
                CFG_CLEAR_DELAY:      r_cfg.clear_delay      <= i_cfg_wdata;
                CFG_LOWPASS_ON:       r_cfg.lowpass_on       <= i_cfg_wdata[0];
                CFG_FOLLOW_ON:        r_cfg.follow_on        <= i_cfg_wdata[0];
                CFG_LAST_CHANNEL:     r_cfg.last_channel     <= i_cfg_wdata[CH_W-1:0];
                CFG_ENABLED_MASK:     r_cfg.enabled_mask     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    tct_chan_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (adv && !r_in_func && ch_ok),
        .i_idx     (idx),
        .i_wdata   (ev),
        .i_capture (adv && r_in_func),
        .i_mask    (r_cfg.enabled_mask),
        .o_rdata   (cur),
        .o_status  (status)
    );

    tct_chan_eval u_eval (
        .i_cfg  (r_cfg),
        .i_cur  (cur),
        .i_raw  (r_in_raw),
        .o_next (ev)
    );

    always_comb begin
        if (r_in_func) begin
            post = cur;
            if (r_cfg.enabled_mask[r_in_ch]) begin
                post.base = cur.filt;
            end
            status_post = status;
        end else begin
            post        = ev;
            status_post = status;
            if (ch_ok) begin
                status_post[r_in_ch] = ev.key;
            end
        end
        keys = status_post & r_cfg.enabled_mask;
        if (!ch_ok) begin
            post = '0;
        end
        n_out_data = {3'b000, keys, post.rel, post.dur, post.count, post.key,
                      post.base, post.filt, r_in_ch};
        n_out_last = !r_in_func && (r_in_ch == r_cfg.last_channel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_func <= i_s_tuser;
            r_in_ch   <= i_s_tdata[CH_W-1:0];
            r_in_raw  <= i_s_tdata[CH_W+CNT_W-1:CH_W];
        end
        if (adv) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    a_keys_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data[92:77] & ~r_cfg.enabled_mask) == '0))
        else $error("pressed keys outside enabled mask");

    a_pressed_no_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data[36]) |-> (r_out_data[76:61] == '0)
            && (r_out_data[44:37] != '0))
        else $error("pressed key with release count or zero press count");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_ready) |=> (r_in_valid && $stable(r_in_ch)
            && $stable(r_in_raw) && $stable(r_in_func)))
        else $error("input stage lost a stalled request");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench for capacitive_touch_channel_tracker: scan and capture requests with random
// idling on both streams, results checked against a cycle-free predictor of the channel state
// depends on tct_pkg and capacitive_touch_channel_tracker
`timescale 1ns / 1ps

module testbench;

    import tct_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int          HOLD_CYCLES = 150;

    typedef struct {
        bit [3:0]  chan;
        bit [15:0] filt;
        bit [15:0] base;
        bit        key;
        bit [7:0]  presses;
        bit [15:0] held;
        bit [15:0] idle;
        bit [15:0] keys;
        bit        sweep;
    } t_touch_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // channel, raw_count, zero pad
    logic        i_s_tuser = 1'b0; // func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // out_channel, filtered_value, baseline_value, key_pressed, press_count,
    // press_duration, release_duration, pressed_keys, zero pad
    logic [95:0] o_m_tdata;
    logic        o_m_tlast;        // sweep_done

    capacitive_touch_channel_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    // channel state as the tracker should hold it
    t_cfg      touch_cfg;
    bit [15:0] filtered_mem [CHANNELS];
    bit [15:0] baseline_mem [CHANNELS];
    bit [15:0] key_bits;
    bit        pressing [CHANNELS];
    bit [15:0] held_mem [CHANNELS];
    bit [7:0]  presses_mem [CHANNELS];
    bit [15:0] released_mem [CHANNELS];

    t_touch_result expected_results [$];
    int unsigned   failures = 0;
    int unsigned   items_sent = 0;
    int unsigned   cycles = 0;
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            hold_req = 0;
    int            hold_seen = 0;
    int            hold_left = 0;
    int            stall_left = 0;

    function automatic void reset_tracker_model();
        touch_cfg = '{press_fraction: 8'd26, release_fraction: 8'd13, repeat_gap: 16'd20,
                      clear_delay: 16'd50, lowpass_on: 1'b1, follow_on: 1'b1,
                      last_channel: 4'd15, enabled_mask: 16'hFFFF};
        key_bits = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            filtered_mem[i] = '0;
            baseline_mem[i] = '0;
            pressing[i] = 1'b0;
            held_mem[i] = '0;
            presses_mem[i] = '0;
            released_mem[i] = '0;
        end
    endfunction

    function automatic t_touch_result track_touch(bit capture, bit [3:0] ch, bit [15:0] raw);
        t_touch_result r;
        bit [17:0] triple;
        bit [16:0] raised;
        bit [15:0] diff;
        bit [31:0] drop;
        bit [15:0] filt;
        bit [15:0] base;
        bit        press_hit;
        bit        release_hit;
        if (capture) begin
            for (int i = 0; i < CHANNELS; i++)
                if (touch_cfg.enabled_mask[i]) baseline_mem[i] = filtered_mem[i];
        end else begin
            triple = 18'(filtered_mem[ch]) * 18'd3;
            filt = touch_cfg.lowpass_on ? 16'(triple[17:2] + 16'(raw[15:4])) : raw;
            filtered_mem[ch] = filt;
            base = baseline_mem[ch];
            if (touch_cfg.follow_on && filt > base) begin
                key_bits[ch] = 1'b0;
                diff = filt - base;
                raised = 17'(base) + 17'((diff > FOLLOW_LIMIT) ? FOLLOW_BIG : FOLLOW_SMALL);
                baseline_mem[ch] = raised[16] ? 16'hFFFF : raised[15:0];
            end else begin
                press_hit = 1'b0;
                release_hit = 1'b1;
                if (filt <= base) begin
                    diff = base - filt;
                    drop = 32'(diff) << 8;
                    press_hit = drop >= 32'(touch_cfg.press_fraction) * 32'(base);
                    release_hit = !press_hit &&
                                  drop <= 32'(touch_cfg.release_fraction) * 32'(base);
                end
                if (press_hit) begin
                    if (touch_cfg.follow_on && base != 16'd0) baseline_mem[ch] = base - 16'd1;
                    key_bits[ch] = 1'b1;
                    if (pressing[ch]) begin
                        if (held_mem[ch] != 16'hFFFF) held_mem[ch]++;
                    end else if (released_mem[ch] < touch_cfg.repeat_gap) begin
                        if (presses_mem[ch] != 8'hFF) presses_mem[ch]++;
                    end else begin
                        presses_mem[ch] = 8'd1;
                    end
                    pressing[ch] = 1'b1;
                    released_mem[ch] = '0;
                end else if (release_hit) begin
                    key_bits[ch] = 1'b0;
                    if (released_mem[ch] >= touch_cfg.repeat_gap) presses_mem[ch] = '0;
                    if (released_mem[ch] >= touch_cfg.clear_delay) held_mem[ch] = '0;
                    if (released_mem[ch] != 16'hFFFF) released_mem[ch]++;
                    pressing[ch] = 1'b0;
                end
            end
        end
        r.chan = ch;
        r.filt = filtered_mem[ch];
        r.base = baseline_mem[ch];
        r.key = key_bits[ch];
        r.presses = presses_mem[ch];
        r.held = held_mem[ch];
        r.idle = released_mem[ch];
        r.keys = key_bits & touch_cfg.enabled_mask;
        r.sweep = !capture && ch == touch_cfg.last_channel;
        return r;
    endfunction

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // result side readiness: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
            stall_left <= idle_gap();
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : result_check
        t_touch_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending: %h", o_m_tdata);
                failures++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_channel", 32'(want.chan), 32'(o_m_tdata[3:0]));
                check_field("filtered_value", 32'(want.filt), 32'(o_m_tdata[19:4]));
                check_field("baseline_value", 32'(want.base), 32'(o_m_tdata[35:20]));
                check_field("key_pressed", 32'(want.key), 32'(o_m_tdata[36]));
                check_field("press_count", 32'(want.presses), 32'(o_m_tdata[44:37]));
                check_field("press_duration", 32'(want.held), 32'(o_m_tdata[60:45]));
                check_field("release_duration", 32'(want.idle), 32'(o_m_tdata[76:61]));
                check_field("pressed_keys", 32'(want.keys), 32'(o_m_tdata[92:77]));
                check_field("sweep_done", 32'(want.sweep), 32'(o_m_tlast));
            end
        end
    end

    task automatic send_request(bit capture, bit [3:0] ch, bit [15:0] raw);
        int gap;
        gap = tx_idle_on ? idle_gap() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= capture;
        i_s_tdata <= {4'b0, raw, ch};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_results.push_back(track_touch(capture, ch, raw));
        items_sent++;
    endtask

    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(t_cfg c);
        wait_idle();
        write_reg(CFG_PRESS_FRACTION, 16'(c.press_fraction));
        write_reg(CFG_RELEASE_FRACTION, 16'(c.release_fraction));
        write_reg(CFG_REPEAT_GAP, c.repeat_gap);
        write_reg(CFG_CLEAR_DELAY, c.clear_delay);
        write_reg(CFG_LOWPASS_ON, 16'(c.lowpass_on));
        write_reg(CFG_FOLLOW_ON, 16'(c.follow_on));
        write_reg(CFG_LAST_CHANNEL, 16'(c.last_channel));
        write_reg(CFG_ENABLED_MASK, c.enabled_mask);
        i_cfg_we <= 1'b0;
        touch_cfg = c;
        @(posedge i_clk);
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        c.press_fraction = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(12, 60));
        c.release_fraction = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(4, 30));
        c.repeat_gap = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        c.clear_delay = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
        c.lowpass_on = 1'($urandom);
        c.follow_on = 1'($urandom);
        c.last_channel = 4'($urandom);
        c.enabled_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        return c;
    endfunction

    // settle a channel, capture it as baseline, then press, hover and release around it
    task automatic touch_episode();
        bit [3:0] ch;
        int level;
        int raw;
        ch = 4'($urandom);
        level = $urandom_range(2000, 60000);
        repeat ($urandom_range(2, 6)) send_request(1'b0, ch, 16'(level + $urandom_range(0, 200)));
        send_request(1'b1, 4'($urandom), 16'($urandom));
        repeat ($urandom_range(6, 16)) begin
            case ($urandom_range(0, 5))
                0, 1: raw = level - level / 4 - $urandom_range(0, level / 4);
                2: raw = level - level * $urandom_range(3, 12) / 100;
                3: raw = level - $urandom_range(0, 50);
                4: raw = level + $urandom_range(0, 3000);
                default: raw = -1;
            endcase
            if (raw < 0)
                send_request($urandom_range(0, 19) == 0, 4'($urandom), 16'($urandom));
            else
                send_request(1'b0, ch, 16'(raw));
        end
    endtask

    task automatic test_reset_values();
        send_request(1'b0, 4'd0, 16'h0000);
        send_request(1'b0, 4'd15, 16'hFFFF);
        send_request(1'b0, 4'd0, 16'h0000);
        send_request(1'b1, 4'd5, 16'hFFFF);
        send_request(1'b0, 4'd15, 16'h0000);
    endtask

    task automatic test_special_cases();
        t_cfg c;
        c = touch_cfg;
        c.lowpass_on = 1'b0;
        c.last_channel = 4'd6;
        c.enabled_mask = 16'h00F0;
        apply_config(c);
        // two big rises while following
        send_request(1'b0, 4'd2, 16'd1000);
        send_request(1'b0, 4'd2, 16'd1055);
        // baseline rising into saturation
        send_request(1'b0, 4'd4, 16'd65530);
        send_request(1'b1, 4'd4, 16'd0);
        send_request(1'b0, 4'd4, 16'hFFFF);
        // press with following, held press, gray zone, rise above baseline
        send_request(1'b0, 4'd6, 16'd40000);
        send_request(1'b1, 4'd6, 16'd0);
        send_request(1'b0, 4'd6, 16'd30000);
        send_request(1'b0, 4'd6, 16'd30000);
        send_request(1'b0, 4'd6, 16'd37500);
        send_request(1'b0, 4'd6, 16'd40000);
        c.follow_on = 1'b0;
        apply_config(c);
        // above baseline without following, release then quick repeat press
        send_request(1'b0, 4'd6, 16'd45000);
        send_request(1'b0, 4'd6, 16'd20000);
        send_request(1'b0, 4'd6, 16'd39990);
        send_request(1'b0, 4'd6, 16'd20000);
        send_request(1'b0, 4'd7, 16'd0);
    endtask

    task automatic test_config_extremes();
        t_cfg c;
        for (int k = 0; k < 4; k++) begin
            c = random_config();
            c.press_fraction = (k == 1 || k == 2) ? 8'hFF : 8'h00;
            c.release_fraction = (k == 1 || k == 3) ? 8'hFF : 8'h00;
            c.repeat_gap = k[0] ? 16'hFFFF : 16'h0000;
            c.clear_delay = k[1] ? 16'hFFFF : 16'h0000;
            c.last_channel = k[0] ? 4'd15 : 4'd0;
            c.enabled_mask = k[1] ? 16'hFFFF : 16'h0000;
            apply_config(c);
            touch_episode();
            touch_episode();
        end
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req <= hold_req + 1;
        repeat (4) touch_episode();
        tx_idle_on = 1'b1;
        wait_idle();
    endtask

    // held press, long release run clears count and duration, then rapid repeat presses
    task automatic test_press_sequences();
        t_cfg c;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        c = '{press_fraction: 8'd26, release_fraction: 8'd13, repeat_gap: 16'd20,
              clear_delay: 16'd50, lowpass_on: 1'b0, follow_on: 1'b0,
              last_channel: 4'd15, enabled_mask: 16'hFFFF};
        apply_config(c);
        send_request(1'b0, 4'd9, 16'd40000);
        send_request(1'b1, 4'd9, 16'd0);
        repeat (20) send_request(1'b0, 4'd9, 16'd20000);
        repeat (55) send_request(1'b0, 4'd9, 16'd40000);
        c.repeat_gap = 16'hFFFF;
        apply_config(c);
        repeat (30) begin
            send_request(1'b0, 4'd9, 16'd20000);
            send_request(1'b0, 4'd9, 16'd40000);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int unsigned phase_end;
        for (int phase = 0; phase < 3; phase++) begin
            apply_config(random_config());
            tx_idle_on = (phase != 1);
            rx_idle_on = (phase != 1);
            phase_end = items_sent + 80;
            while (items_sent < phase_end) touch_episode();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        reset_tracker_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_special_cases();
        test_config_extremes();
        test_backpressure();
        test_press_sequences();
        test_random_traffic();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (failures == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
